// ----- rtl/core/lnps_pkg.sv -----
// ----------------------------------------------------------------------------
// lnps_pkg
// shared types and constants for the last-note priority stack
// ----------------------------------------------------------------------------
package lnps_pkg;

  // held-note stack depth
  localparam int unsigned STACK_DEPTH = 8;

  // stack index and fill count widths
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  // note and pitch widths
  localparam int unsigned NOTE_W  = 6;
  localparam int unsigned MIDI_W  = 7;
  localparam int unsigned PITCH_W = 8;

  // clamp window on the incoming note number
  localparam logic [MIDI_W-1:0] NOTE_FLOOR = 7'd36;
  localparam logic [MIDI_W-1:0] NOTE_CEIL  = 7'd96;

  // command codes
  localparam logic CMD_NOTE_ON  = 1'b0;
  localparam logic CMD_NOTE_OFF = 1'b1;

  // retrigger modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_ALWAYS = 2'd2;

  // gate actions
  localparam logic [1:0] GATE_KEEP   = 2'd0;
  localparam logic [1:0] GATE_OPEN   = 2'd1;
  localparam logic [1:0] GATE_RETRIG = 2'd2;
  localparam logic [1:0] GATE_CLOSE  = 2'd3;

  // register map
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_RETRIG = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_TAIL,
    ST_EMIT
  } lnps_state_e;

  // control from the sequencer to the stack storage
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [NOTE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } lnps_stack_req_t;

endpackage

// ----- rtl/core/lnps_stack.sv -----
// ----------------------------------------------------------------------------
// lnps_stack
// held-note storage with one read port, one write port and the note comparator
// ----------------------------------------------------------------------------
module lnps_stack (
  input  logic                         clk_i,
  input  lnps_pkg::lnps_stack_req_t    req_i,
  input  logic [lnps_pkg::NOTE_W-1:0]  cmp_note_i,
  output logic [lnps_pkg::NOTE_W-1:0]  rdata_o,
  output logic                         match_o
);

  logic [lnps_pkg::NOTE_W-1:0] notes_q [lnps_pkg::STACK_DEPTH];
  logic [lnps_pkg::NOTE_W-1:0] rdata_q;

  // contents are undefined until written, so no reset
  // read data is registered, the address comes in the cycle before
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      notes_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= notes_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;
  assign match_o = (rdata_q == cmp_note_i);

endmodule

// ----- rtl/core/last_note_priority_stack_core.sv -----
// ----------------------------------------------------------------------------
// last_note_priority_stack_core
// monophonic last-note priority stack: note events in, pitch and gate out
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | to core   | in_valid_i / in_stall_o    | command_i, note_number_i
//  out     | from core | out_valid_o / out_stall_i  | pitch_update_o, pitch_code_o,
//          |           |                            | gate_action_o
//  cfg     | to core   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  one request walks the stack through a single shared compare unit:
//  a note on scans for a match and pushes a new note if there is room; a note
//  off scans, shifts the entries above the match down and reads the new top
//  the input stalls while the sequencer is busy; a finished result sits in
//  the output register so a new request can start while it waits
//  reset empties the stack (fill count only) and sets retrigger mode to none
// ----------------------------------------------------------------------------
module last_note_priority_stack_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // note events
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [6:0]                     note_number_i,
  // pitch and gate results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pitch_update_o,
  output logic [7:0]                     pitch_code_o,
  output logic [1:0]                     gate_action_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lnps_pkg::PADDR_W-1:0]   paddr,
  input  logic [lnps_pkg::PDATA_W-1:0]   pwdata,
  output logic [lnps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned IW = lnps_pkg::IDX_W;
  localparam int unsigned CW = lnps_pkg::CNT_W;
  localparam int unsigned NW = lnps_pkg::NOTE_W;

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  logic [1:0] mode_q;
  logic       cfg_wr;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lnps_pkg::MODE_NONE;
    end else if (cfg_wr && (reg_idx == lnps_pkg::REG_RETRIG)) begin
      mode_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lnps_pkg::REG_RETRIG: prdata[1:0] = mode_q;
      default:              prdata      = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  lnps_pkg::lnps_state_e state_q, state_d;

  logic          cmd_q,   cmd_d;
  logic [NW-1:0] note_q,  note_d;
  logic [CW-1:0] idx_q,   idx_d;
  logic [CW-1:0] count_q, count_d;

  // pending result, built by the sequencer
  logic          res_upd_q,  res_upd_d;
  logic [NW-1:0] res_note_q, res_note_d;
  logic [1:0]    res_gate_q, res_gate_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_upd_q,   out_upd_d;
  logic [7:0]    out_code_q,  out_code_d;
  logic [1:0]    out_gate_q,  out_gate_d;

  // stack interface
  lnps_pkg::lnps_stack_req_t stack_req;
  logic [NW-1:0]             stack_rdata;
  logic                      stack_match;

  // shared compare unit flags
  logic          in_acc;
  logic          scan_end;
  logic          full;
  logic          shift_more;
  logic          out_free;
  logic [CW-1:0] idx_nxt;
  logic [CW-1:0] idx_skip;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] prev_top;
  logic [NW-1:0] clamped;

  assign in_stall_o = (state_q != lnps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign idx_nxt    = idx_q + CW'(1);
  assign idx_skip   = idx_q + CW'(2);
  assign top_idx    = count_q - CW'(1);
  assign prev_top   = count_q - CW'(2);
  assign scan_end   = (idx_q == count_q);
  assign full       = (count_q == CW'(lnps_pkg::STACK_DEPTH));
  assign shift_more = (idx_nxt < count_q);
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // clamp to 36..96 and offset down to 0..60
  always_comb begin
    if (note_number_i < lnps_pkg::NOTE_FLOOR) begin
      clamped = '0;
    end else if (note_number_i > lnps_pkg::NOTE_CEIL) begin
      clamped = NW'(lnps_pkg::NOTE_CEIL - lnps_pkg::NOTE_FLOOR);
    end else begin
      clamped = NW'(note_number_i - lnps_pkg::NOTE_FLOOR);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lnps_pkg::ST_IDLE: begin
        if (in_acc) state_d = lnps_pkg::ST_SCAN;
      end
      lnps_pkg::ST_SCAN: begin
        if (scan_end) begin
          // note off of an unheld note, or no room for a new note: drop it
          if ((cmd_q == lnps_pkg::CMD_NOTE_OFF) || full) begin
            state_d = lnps_pkg::ST_IDLE;
          end else begin
            state_d = lnps_pkg::ST_EMIT;
          end
        end else if (stack_match) begin
          state_d = (cmd_q == lnps_pkg::CMD_NOTE_OFF) ? lnps_pkg::ST_SHIFT
                                                      : lnps_pkg::ST_EMIT;
        end
      end
      lnps_pkg::ST_SHIFT: begin
        if (!shift_more) state_d = lnps_pkg::ST_TAIL;
      end
      lnps_pkg::ST_TAIL: state_d = lnps_pkg::ST_EMIT;
      lnps_pkg::ST_EMIT: begin
        if (out_free) state_d = lnps_pkg::ST_IDLE;
      end
      default: state_d = lnps_pkg::ST_IDLE;
    endcase
  end

  // datapath and stack control
  // stack reads are registered, so each state presents the address that the
  // next cycle compares or copies
  always_comb begin
    cmd_d       = cmd_q;
    note_d      = note_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_upd_d   = res_upd_q;
    res_note_d  = res_note_q;
    res_gate_d  = res_gate_q;
    out_upd_d   = out_upd_q;
    out_code_d  = out_code_q;
    out_gate_d  = out_gate_q;
    out_valid_d = out_valid_q & out_stall_i;

    stack_req.we    = 1'b0;
    stack_req.waddr = count_q[IW-1:0];
    stack_req.wdata = note_q;
    stack_req.raddr = idx_q[IW-1:0];

    unique case (state_q)
      lnps_pkg::ST_IDLE: begin
        // scan starts at the bottom entry
        stack_req.raddr = '0;
        if (in_acc) begin
          cmd_d  = command_i;
          note_d = clamped;
          idx_d  = '0;
        end
      end
      lnps_pkg::ST_SCAN: begin
        // next entry up, also the first source entry of a removal
        stack_req.raddr = idx_nxt[IW-1:0];
        if (scan_end) begin
          if ((cmd_q == lnps_pkg::CMD_NOTE_ON) && !full) begin
            // push the new note on top
            stack_req.we = 1'b1;
            count_d      = count_q + CW'(1);
            res_upd_d    = 1'b1;
            res_note_d   = note_q;
            res_gate_d   = (mode_q != lnps_pkg::MODE_NONE) ? lnps_pkg::GATE_RETRIG
                                                           : lnps_pkg::GATE_OPEN;
          end
        end else if (stack_match) begin
          // held note on: re-send pitch, gate untouched
          res_upd_d  = 1'b1;
          res_note_d = note_q;
          res_gate_d = lnps_pkg::GATE_KEEP;
        end else begin
          idx_d = idx_nxt;
        end
      end
      lnps_pkg::ST_SHIFT: begin
        // close the gap left by the released note, one entry a cycle
        if (shift_more) begin
          stack_req.we    = 1'b1;
          stack_req.waddr = idx_q[IW-1:0];
          stack_req.wdata = stack_rdata;
          stack_req.raddr = idx_skip[IW-1:0];
          idx_d           = idx_nxt;
        end else begin
          // new top of the shortened stack
          stack_req.raddr = prev_top[IW-1:0];
          count_d         = top_idx;
        end
      end
      lnps_pkg::ST_TAIL: begin
        // return to the previous note, or close the gate when none is left
        if (count_q == '0) begin
          res_upd_d  = 1'b0;
          res_note_d = '0;
          res_gate_d = lnps_pkg::GATE_CLOSE;
        end else begin
          res_upd_d  = 1'b1;
          res_note_d = stack_rdata;
          res_gate_d = (mode_q == lnps_pkg::MODE_ALWAYS) ? lnps_pkg::GATE_RETRIG
                                                         : lnps_pkg::GATE_OPEN;
        end
      end
      lnps_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_upd_d   = res_upd_q;
          out_code_d  = {res_note_q, 2'b00};
          out_gate_d  = res_gate_q;
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lnps_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    note_q     <= note_d;
    idx_q      <= idx_d;
    res_upd_q  <= res_upd_d;
    res_note_q <= res_note_d;
    res_gate_q <= res_gate_d;
    out_upd_q  <= out_upd_d;
    out_code_q <= out_code_d;
    out_gate_q <= out_gate_d;
  end

  lnps_stack u_stack (
    .clk_i      (clk_i),
    .req_i      (stack_req),
    .cmp_note_i (note_q),
    .rdata_o    (stack_rdata),
    .match_o    (stack_match)
  );

  assign out_valid_o    = out_valid_q;
  assign pitch_update_o = out_upd_q;
  assign pitch_code_o   = out_code_q;
  assign gate_action_o  = out_gate_q;

endmodule

// ----- rtl/core/lnps_checker.sv -----
// ----------------------------------------------------------------------------
// lnps_checker
// port-level checks on the last-note priority stack
// ----------------------------------------------------------------------------
module lnps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       pitch_update_o,
  input logic [7:0] pitch_code_o,
  input logic [1:0] gate_action_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pitch_code_o)
      && $stable(gate_action_o) && $stable(pitch_update_o))
    else $error("stalled result changed");

  // an accepted request keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken back to back");

  // a closed gate carries no pitch
  a_close_no_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gate_action_o == lnps_pkg::GATE_CLOSE
      |-> !pitch_update_o && pitch_code_o == 8'd0)
    else $error("gate close with pitch");

  // without a pitch update the gate must close
  a_no_pitch_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pitch_update_o |-> gate_action_o == lnps_pkg::GATE_CLOSE)
    else $error("missing pitch update");

  // pitch code is a clamped note times four
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_code_o <= 8'd240 && pitch_code_o[1:0] == 2'b00)
    else $error("pitch code out of range");

endmodule

bind last_note_priority_stack_core lnps_checker u_lnps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pitch_update_o (pitch_update_o),
  .pitch_code_o   (pitch_code_o),
  .gate_action_o  (gate_action_o)
);

// ----- tb/last_note_priority_stack_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// last_note_priority_stack_core_tb
// self-checking bench for the last-note priority stack core: note events are
// queued by a stimulus process, pushed through the valid/stall input by a
// clocked driver, and every result is checked against a behavioral copy of
// the held-note stack, across all retrigger modes and several idle patterns
// ----------------------------------------------------------------------------
module last_note_priority_stack_core_tb;
  import lnps_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 2 * (STACK_DEPTH + 3);
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 400_000;
  localparam int MAX_REPORTS   = 10;
  localparam int NOTE_MAX      = 2**MIDI_W - 1;
  localparam int PHASES        = 7;
  localparam int PHASE_EVENTS  = 260;
  localparam int CHUNK_EVENTS  = 30;

  // retrigger modes without a name in the package
  localparam logic [1:0] MODE_NEW      = 2'd1;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [PADDR_W-1:0] RETRIG_ADDR = PADDR_W'(4 * int'(REG_RETRIG));

  // one note event as it enters the core
  typedef struct packed {
    logic              cmd;
    logic [MIDI_W-1:0] note;
  } note_req_t;

  // one pitch/gate result
  typedef struct packed {
    logic               upd;
    logic [PITCH_W-1:0] code;
    logic [1:0]         gate;
  } pitch_gate_t;

  // dut ports, inputs all known from time zero
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               command_i      = CMD_NOTE_ON;
  logic [MIDI_W-1:0]  note_number_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               pitch_update_o;
  logic [PITCH_W-1:0] pitch_code_o;
  logic [1:0]         gate_action_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // stimulus and expectation stores
  note_req_t   note_events [$];
  pitch_gate_t pending_pitch [$];

  // behavioral copy of the core state
  logic [NOTE_W-1:0] stack_notes [STACK_DEPTH];
  int                stack_fill = 0;
  logic [1:0]        cfg_retrig = MODE_NONE;

  // idle controls, written by the stimulus process only
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int long_hold_reqs = 0;

  // receiver hold-off bookkeeping, owned by the stall process
  int hold_seen = 0;
  int hold_left = 0;

  logic in_fired = 1'b0;
  int   err_cnt  = 0;
  int   cycle_cnt = 0;

  last_note_priority_stack_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .note_number_i  (note_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pitch_update_o (pitch_update_o),
    .pitch_code_o   (pitch_code_o),
    .gate_action_o  (gate_action_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // error reporting: first few in full, the rest only counted
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    if (err_cnt < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0d got %0d", what, want, got));
  endtask

  // ---------------------------------------------------------------------------
  // held-note stack behavior
  // ---------------------------------------------------------------------------

  // clamp to the playable window and shift down to zero
  function automatic logic [NOTE_W-1:0] fold_note(logic [MIDI_W-1:0] raw);
    if (raw < NOTE_FLOOR) return '0;
    if (raw > NOTE_CEIL) return NOTE_W'(NOTE_CEIL - NOTE_FLOOR);
    return NOTE_W'(raw - NOTE_FLOOR);
  endfunction

  // applies one note event to the stack copy and yields the pitch/gate result
  task automatic play_event(input note_req_t ev, output bit has_res, output pitch_gate_t res);
    logic [NOTE_W-1:0] n;
    int hit;
    int i;
    has_res = 1'b0;
    res     = '0;
    n       = fold_note(ev.note);
    hit     = -1;
    for (i = 0; i < stack_fill; i++)
      if (hit < 0 && stack_notes[i] == n) hit = i;

    if (ev.cmd == CMD_NOTE_ON) begin
      if (hit >= 0) begin
        // already held: pitch again, gate untouched
        has_res = 1'b1;
        res     = '{upd: 1'b1, code: {n, 2'b00}, gate: GATE_KEEP};
      end else if (stack_fill < STACK_DEPTH) begin
        stack_notes[stack_fill] = n;
        stack_fill++;
        has_res = 1'b1;
        res     = '{upd: 1'b1, code: {n, 2'b00},
                    gate: (cfg_retrig != MODE_NONE) ? GATE_RETRIG : GATE_OPEN};
      end
      // full stack drops a new note silently
    end else if (hit >= 0) begin
      // remove and close the gap, order of the rest kept
      for (i = hit; i + 1 < stack_fill; i++) stack_notes[i] = stack_notes[i + 1];
      stack_fill--;
      has_res = 1'b1;
      if (stack_fill > 0)
        res = '{upd: 1'b1, code: {stack_notes[stack_fill - 1], 2'b00},
                gate: (cfg_retrig == MODE_ALWAYS) ? GATE_RETRIG : GATE_OPEN};
      else
        res = '{upd: 1'b0, code: '0, gate: GATE_CLOSE};
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: new request at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_events
    note_req_t nxt;
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (note_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt           = note_events.pop_front();
        in_valid_i    <= 1'b1;
        command_i     <= nxt.cmd;
        note_number_i <= nxt.note;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall: random per phase, plus a long hold-off on demand
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_seen != long_hold_reqs) begin
      hold_seen   <= long_hold_reqs;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, predict accepted requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    pitch_gate_t want;
    note_req_t   ev;
    bit          has_res;
    if (!rst_ni) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid_i && !in_stall_o;

      if (out_valid_o && !out_stall_i) begin
        if (pending_pitch.size() == 0) begin
          flag_error($sformatf("result with nothing expected: upd %0b code %0d gate %0d",
                               pitch_update_o, pitch_code_o, gate_action_o));
        end else begin
          want = pending_pitch.pop_front();
          check_field("pitch_update", 32'(want.upd), 32'(pitch_update_o));
          check_field("pitch_code", 32'(want.code), 32'(pitch_code_o));
          check_field("gate_action", 32'(want.gate), 32'(gate_action_o));
        end
      end

      // a result never leaves in the cycle its request enters, so order holds
      if (in_valid_i && !in_stall_o) begin
        ev.cmd  = command_i;
        ev.note = note_number_i;
        play_event(ev, has_res, want);
        if (has_res) pending_pitch.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("last_note_priority_stack_core_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------
  task automatic write_retrig(logic [1:0] mode);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RETRIG_ADDR;
    pwdata  <= PDATA_W'(mode);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_retrig = mode;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_retrig();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= RETRIG_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("retrigger_mode readback", PDATA_W'(cfg_retrig), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_event(logic cmd, int note);
    note_events.push_back('{cmd: cmd, note: MIDI_W'(note)});
  endtask

  // bursts from a small note pool so notes get held, repeated and released;
  // a few events are plain noise over the full field range
  task automatic queue_random_events(int count);
    logic [MIDI_W-1:0] pool [16];
    int pool_n;
    int k;
    int j;
    pool_n = 1;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        pool_n = $urandom_range(14, 2);
        for (j = 0; j < pool_n; j++)
          pool[j] = ($urandom_range(99) < 80) ? MIDI_W'($urandom_range(NOTE_CEIL, NOTE_FLOOR))
                                              : MIDI_W'($urandom_range(NOTE_MAX, 0));
      end
      if ($urandom_range(99) < 10)
        add_event(1'($urandom_range(1, 0)), int'($urandom_range(NOTE_MAX, 0)));
      else
        add_event(($urandom_range(99) < 55) ? CMD_NOTE_ON : CMD_NOTE_OFF,
                  int'(pool[$urandom_range(pool_n - 1, 0)]));
    end
  endtask

  // everything sent, every result back, core given time to finish silent events
  task automatic wait_quiet();
    while (note_events.size() != 0 || in_valid_i || pending_pitch.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [1:0] mode;
    int p;
    int c;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset value of the mode register
    read_retrig();

    // directed: empty stack, clamping at both ends, held re-press,
    // last release, full stack, top and bottom removal
    add_event(CMD_NOTE_OFF, 60);         // nothing held, ignored
    add_event(CMD_NOTE_ON, 0);           // clamps to lowest note
    add_event(CMD_NOTE_ON, NOTE_MAX);    // clamps to highest note
    add_event(CMD_NOTE_ON, 35);          // same clamped note as 0, held
    add_event(CMD_NOTE_OFF, 50);         // not held, ignored
    add_event(CMD_NOTE_OFF, 36);         // bottom removed, back to top note
    add_event(CMD_NOTE_OFF, 96);         // last note released, gate closes
    for (c = 0; c < STACK_DEPTH; c++) add_event(CMD_NOTE_ON, 40 + c);
    add_event(CMD_NOTE_ON, 100);         // stack full, dropped
    add_event(CMD_NOTE_ON, 43);          // held while full
    add_event(CMD_NOTE_OFF, 40 + STACK_DEPTH - 1);
    add_event(CMD_NOTE_OFF, 40);
    add_event(CMD_NOTE_OFF, NOTE_MAX);   // not held, ignored
    wait_quiet();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin mode = MODE_NEW;      send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin mode = MODE_ALWAYS;   send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin mode = MODE_RESERVED; send_idle_pct = 0;  recv_stall_pct = 79; end
        3:       begin mode = MODE_NONE;     send_idle_pct = 29; recv_stall_pct = 29; end
        4:       begin mode = MODE_ALWAYS;   send_idle_pct = 0;  recv_stall_pct = 0;  end
        5:       begin mode = MODE_NEW;      send_idle_pct = 0;  recv_stall_pct = 29; end
        default: begin mode = MODE_ALWAYS;   send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      write_retrig(mode);
      read_retrig();

      if (p == 4) begin
        // long output hold-off with the sender still pushing: core fills and stalls
        long_hold_reqs++;
        queue_random_events(PHASE_EVENTS);
      end else if (p == 5) begin
        // sender pauses after each short burst until all results are back
        for (c = 0; c < PHASE_EVENTS / CHUNK_EVENTS; c++) begin
          queue_random_events(CHUNK_EVENTS);
          wait_quiet();
        end
      end else begin
        queue_random_events(PHASE_EVENTS);
      end
      wait_quiet();
    end

    if (pending_pitch.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_pitch.size()));

    if (err_cnt == 0) begin
      $display("last_note_priority_stack_core_tb: clean");
    end else begin
      $display("last_note_priority_stack_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lnps_pkg.sv
rtl/core/lnps_stack.sv
rtl/core/last_note_priority_stack_core.sv
rtl/core/lnps_checker.sv
tb/last_note_priority_stack_core_tb.sv
